>>> src/pmpu_pkg.sv
package pmpu_pkg;
  localparam int WordBitsDefault = 64;
  localparam int FieldBits = 64;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NEG_EXP  = 2'd1,
    ERR_ZERO_MOD = 2'd2,
    ERR_NEG_MOD  = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    OP_WRAP_MUL = 2'd0,
    OP_MOD_MUL  = 2'd1,
    OP_MOD_RED  = 2'd2
  } alu_op_t;
endpackage

>>> src/pmpu_alu.sv
// Shared arithmetic unit. A wrapping multiply takes one step per multiplier bit
// (shift and add). A modular multiply takes one double-and-add step per bit of
// the multiplier, MSB first. A reduction of a nonnegative value takes one
// restoring step per dividend bit.
module pmpu_alu #(
  parameter int WORD_BITS = pmpu_pkg::WordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  pmpu_pkg::alu_op_t    op,
  input  logic [WORD_BITS-1:0] opa,
  input  logic [WORD_BITS-1:0] opb,
  input  logic [WORD_BITS-1:0] modu,
  output logic                 done,
  output logic [WORD_BITS-1:0] res
);
  import pmpu_pkg::*;

  localparam int CntBits = $clog2(WORD_BITS + 1);

  logic                 busy_r;
  alu_op_t              op_r;
  logic [CntBits-1:0]   cnt_r;
  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] b_r;
  logic [WORD_BITS-1:0] m_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] acc_nxt;
  logic                 done_r;

  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS-1:0] dbl_red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS-1:0] sum_red;
  logic [WORD_BITS:0]   rem_sh;

  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? WORD_BITS'(dbl - {1'b0, m_r}) : dbl[WORD_BITS-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, a_r};
    sum_red = (sum >= {1'b0, m_r}) ? WORD_BITS'(sum - {1'b0, m_r}) : sum[WORD_BITS-1:0];
    rem_sh  = {acc_r, b_r[WORD_BITS-1]};
    acc_nxt = acc_r;
    unique case (op_r)
      OP_WRAP_MUL: acc_nxt = b_r[0] ? acc_r + a_r : acc_r;
      OP_MOD_MUL:  acc_nxt = b_r[WORD_BITS-1] ? sum_red : dbl_red;
      OP_MOD_RED:  acc_nxt = (rem_sh >= {1'b0, m_r}) ?
                             WORD_BITS'(rem_sh - {1'b0, m_r}) : rem_sh[WORD_BITS-1:0];
      default:     acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_WRAP_MUL;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= op;
        cnt_r  <= CntBits'(WORD_BITS);
        a_r    <= opa;
        b_r    <= opb;
        m_r    <= modu;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        if (op_r == OP_WRAP_MUL) begin
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end else begin
          b_r <= b_r << 1;
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntBits'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("alu done without work");

  property p_no_busy_done;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r;
  endproperty
  a_no_busy_done: assert property (p_no_busy_done) else $error("alu done while busy");

  property p_red_below_mod;
    @(posedge clk) disable iff (!rst_n)
      (done_r && op_r != OP_WRAP_MUL) |-> (acc_r < m_r);
  endproperty
  a_red_below_mod: assert property (p_red_below_mod) else $error("residue not below modulus");
endmodule

>>> src/power_and_modular_power_unit.sv
// An error goes from idle straight to the done state; a zero exponent in mode 0 passes
// through the multiply-go state to done. Each multiply, squaring or reduction runs on the
// shared arithmetic unit.
// Throughput: one transaction at a time; busy stays high until out_valid pulses.
// The result is shown for one cycle with out_valid, the receiver cannot stall.
// Reset: synchronous, active low; clears the sequencer, nothing else needs it.
module power_and_modular_power_unit #(
  parameter int WORD_BITS = pmpu_pkg::WordBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic signed [pmpu_pkg::FieldBits-1:0] in_base,
  input  logic signed [pmpu_pkg::FieldBits-1:0] in_exponent,
  input  logic signed [pmpu_pkg::FieldBits-1:0] in_modulus,
  output logic                              out_valid,
  output logic signed [pmpu_pkg::FieldBits-1:0] out_result,
  output logic [1:0]                        out_error_code
);
  import pmpu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_MUL_GO, S_MUL_WAIT, S_SQ_GO, S_SQ_WAIT, S_DONE
  } state_t;

  state_t               state_r;
  logic                 mode_r;
  logic [WORD_BITS-1:0] b_r;
  logic [WORD_BITS-1:0] e_r;
  logic [WORD_BITS-1:0] m_r;
  logic [WORD_BITS-1:0] acc_r;
  logic                 neg_base_r;
  logic                 red_go_r;
  logic                 out_valid_r;
  logic [FieldBits-1:0] result_r;
  err_code_t            err_r;

  logic                 alu_go;
  alu_op_t              alu_op;
  logic [WORD_BITS-1:0] alu_a;
  logic [WORD_BITS-1:0] alu_b;
  logic                 alu_done;
  logic [WORD_BITS-1:0] alu_res;

  logic [WORD_BITS-1:0] base_w;
  logic [WORD_BITS-1:0] exp_w;
  logic [WORD_BITS-1:0] mod_w;
  logic [WORD_BITS-1:0] one_mod;

  assign base_w  = in_base[WORD_BITS-1:0];
  assign exp_w   = in_exponent[WORD_BITS-1:0];
  assign mod_w   = in_modulus[WORD_BITS-1:0];
  assign one_mod = (mod_w == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

  always_comb begin
    alu_go = 1'b0;
    alu_op = mode_r ? OP_MOD_MUL : OP_WRAP_MUL;
    alu_a  = acc_r;
    alu_b  = b_r;
    unique case (state_r)
      S_REDUCE: begin
        alu_go = red_go_r;
        alu_op = OP_MOD_RED;
        alu_a  = '0;
        alu_b  = neg_base_r ? ~b_r : b_r;
      end
      // The unit only starts when this exponent bit actually needs a multiply.
      S_MUL_GO: alu_go = e_r[0];
      S_SQ_GO: begin
        alu_go = (e_r[WORD_BITS-1:1] != '0);
        alu_a  = b_r;
      end
      default: ;
    endcase
  end

  pmpu_alu #(.WORD_BITS(WORD_BITS)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (alu_go),
    .op   (alu_op),
    .opa  (alu_a),
    .opb  (alu_b),
    .modu (m_r),
    .done (alu_done),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      red_go_r    <= 1'b0;
      err_r       <= ERR_NONE;
      result_r    <= '0;
    end else begin
      out_valid_r <= 1'b0;
      red_go_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r     <= in_mode;
            b_r        <= base_w;
            e_r        <= exp_w;
            m_r        <= mod_w;
            neg_base_r <= base_w[WORD_BITS-1];
            err_r      <= ERR_NONE;
            acc_r      <= in_mode ? one_mod : WORD_BITS'(1);
            if (exp_w[WORD_BITS-1]) begin
              err_r   <= ERR_NEG_EXP;
              acc_r   <= '0;
              state_r <= S_DONE;
            end else if (in_mode && mod_w == '0) begin
              err_r   <= ERR_ZERO_MOD;
              acc_r   <= '0;
              state_r <= S_DONE;
            end else if (in_mode && mod_w[WORD_BITS-1]) begin
              err_r   <= ERR_NEG_MOD;
              acc_r   <= '0;
              state_r <= S_DONE;
            end else if (in_mode) begin
              red_go_r <= 1'b1;
              state_r  <= S_REDUCE;
            end else begin
              state_r <= S_MUL_GO;
            end
          end
        end
        S_REDUCE: begin
          if (alu_done) begin
            // Floored reduction of a negative base: m - 1 - (~b mod m).
            b_r     <= neg_base_r ? m_r - WORD_BITS'(1) - alu_res : alu_res;
            state_r <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          if (e_r == '0) begin
            state_r <= S_DONE;
          end else if (e_r[0]) begin
            state_r <= S_MUL_WAIT;
          end else begin
            state_r <= S_SQ_GO;
          end
        end
        S_MUL_WAIT: begin
          if (alu_done) begin
            acc_r   <= alu_res;
            state_r <= S_SQ_GO;
          end
        end
        S_SQ_GO: begin
          e_r <= e_r >> 1;
          // Skip the last squaring when no exponent bits remain.
          state_r <= ((e_r >> 1) == '0) ? S_DONE : S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (alu_done) begin
            b_r     <= alu_res;
            state_r <= S_MUL_GO;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          result_r    <= FieldBits'($signed(acc_r));
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_result     = result_r;
  assign out_error_code = err_r;

  property p_err_zero_result;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && err_r != ERR_NONE) |-> (result_r == '0);
  endproperty
  a_err_zero_result: assert property (p_err_zero_result) else $error("error with nonzero result");

  property p_valid_one_cycle;
    @(posedge clk) disable iff (!rst_n) out_valid_r |=> !out_valid_r;
  endproperty
  a_valid_one_cycle: assert property (p_valid_one_cycle) else $error("result held two cycles");

  property p_valid_idle;
    @(posedge clk) disable iff (!rst_n) out_valid_r |-> (state_r == S_IDLE);
  endproperty
  a_valid_idle: assert property (p_valid_idle) else $error("result while still working");
endmodule

>>> verif/power_and_modular_power_unit_tb.sv
`timescale 1ns / 1ps

module power_and_modular_power_unit_tb;
  import pmpu_pkg::*;

  localparam int WatchdogLimit = 200000;
  localparam int DrainCycles = 20;

  typedef struct {
    logic signed [63:0] result;
    err_code_t          error_code;
  } power_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic signed [63:0] in_base = '0;
  logic signed [63:0] in_exponent = '0;
  logic signed [63:0] in_modulus = '0;
  logic out_valid;
  logic signed [63:0] out_result;
  logic [1:0] out_error_code;

  int errors = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  power_and_modular_power_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_base(in_base), .in_exponent(in_exponent),
    .in_modulus(in_modulus), .out_valid(out_valid), .out_result(out_result),
    .out_error_code(out_error_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] m);
    logic [127:0] p;
    p = a * b;
    p = p % m;
    return p[63:0];
  endfunction

  function automatic power_result_t predict_power(logic mode, logic [63:0] base,
                                                  logic [63:0] expo,
                                                  logic [63:0] modu);
    power_result_t r;
    logic [63:0] acc, b;
    r.result = '0;
    r.error_code = ERR_NONE;
    if (expo[63]) begin
      r.error_code = ERR_NEG_EXP;
    end else if (!mode) begin
      acc = 64'd1;
      b = base;
      while (expo != 0) begin
        if (expo[0]) acc = acc * b;
        b = b * b;
        expo = expo >> 1;
      end
      r.result = acc;
    end else if (modu == 0) begin
      r.error_code = ERR_ZERO_MOD;
    end else if (modu[63]) begin
      r.error_code = ERR_NEG_MOD;
    end else begin
      // Floored reduction keeps a negative base in 0 to modulus-1.
      if (base[63]) b = modu - 64'd1 - ((~base) % modu);
      else b = base % modu;
      acc = 64'd1 % modu;
      while (expo != 0) begin
        if (expo[0]) acc = mulmod(acc, b, modu);
        b = mulmod(b, b, modu);
        expo = expo >> 1;
      end
      r.result = acc;
    end
    return r;
  endfunction

  class power_scoreboard;
    power_result_t pending[$];

    function void note_input(logic mode, logic [63:0] base, logic [63:0] expo,
                             logic [63:0] modu);
      pending.push_back(predict_power(mode, base, expo, modu));
    endfunction

    task check_result(logic signed [63:0] result, logic [1:0] code);
      power_result_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
        return;
      end
      exp_r = pending.pop_front();
      if (result !== exp_r.result)
        report_mismatch($sformatf("result %h, expected %h", result, exp_r.result));
      if (code !== exp_r.error_code)
        report_mismatch($sformatf("error_code %0d, expected %0d", code,
                                  exp_r.error_code));
    endtask
  endclass

  power_scoreboard sb = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_input(in_mode, in_base, in_exponent, in_modulus);
      if (out_valid)
        sb.check_result(out_result, out_error_code);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("power_and_modular_power_unit_tb NOT OK");
      $finish;
    end
  end

  // Sends one transaction, holding start, and returns once busy is found low.
  task automatic send_power(input logic mode, input logic [63:0] base,
                            input logic [63:0] expo, input logic [63:0] modu);
    start <= 1'b1;
    in_mode <= mode;
    in_base <= base;
    in_exponent <= expo;
    in_modulus <= modu;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 5));
      1: v = -$signed(64'($urandom_range(1, 5)));
      2: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_exponent();
    // Most exponents stay short so the run does not crawl.
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return {1'b1, 63'($urandom)};
      2: return 64'($urandom_range(0, 3));
      default: return 64'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int burst;
    int gap;
    logic [63:0] maxp, minn;
    maxp = {1'b0, {63{1'b1}}};
    minn = {1'b1, 63'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_power(1'b0, 64'd3, 64'd5, 64'd0);
    send_power(1'b0, minn, 64'd2, minn);
    send_power(1'b0, maxp, maxp, 64'd7);
    send_power(1'b0, -64'sd1, 64'd63, 64'd0);
    send_power(1'b0, 64'd0, 64'd0, 64'd0);
    send_power(1'b0, 64'd2, 64'd64, maxp);
    send_power(1'b0, 64'd5, -64'sd1, 64'd0);
    send_power(1'b1, 64'd5, minn, 64'd0);
    send_power(1'b1, 64'd5, 64'd3, 64'd0);
    send_power(1'b1, 64'd5, 64'd3, minn);
    send_power(1'b1, 64'd5, 64'd3, -64'sd1);
    send_power(1'b1, 64'd9, 64'd0, 64'd1);
    send_power(1'b1, maxp, maxp, 64'd1);
    send_power(1'b1, 64'd9, 64'd0, 64'd13);
    send_power(1'b1, -64'sd7, 64'd3, 64'd10);
    send_power(1'b1, minn, maxp, maxp);
    send_power(1'b1, maxp, maxp, maxp - 64'd1);
    send_power(1'b1, -64'sd1, 64'd1, maxp);
    send_power(1'b1, 64'd0, 64'd0, maxp);
    send_power(1'b1, {$urandom, $urandom}, maxp, 64'd1000000007);

    for (int n = 0; n < 110; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < 110; k++, n++)
        send_power(1'($urandom_range(0, 1)), rand_word(), rand_exponent(), rand_word());
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("power_and_modular_power_unit_tb OK");
    else
      $display("power_and_modular_power_unit_tb NOT OK");
    $finish;
  end
endmodule
